// ===== hw/rtl/sha256_pkg.sv =====
// Package: SHA-256 constants, round table and helper functions.
`default_nettype none
package sha256_pkg;

  localparam int unsigned DIGEST_WORDS = 8;
  localparam int unsigned SCHED_DEPTH  = 16;
  localparam int unsigned ROUNDS       = 64;
  localparam logic [7:0]  PAD_BYTE     = 8'h80;
  localparam logic [5:0]  LEN_POS      = 6'd56;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    begin
      case (t)
        6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
        6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
        6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
        6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
        6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
        6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
        6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
        6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
        6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
        6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
        6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
        6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
        6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
        6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
        6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
        6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
        6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
        6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
        6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
        6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
        6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
        default: k = 32'hc67178f2;
      endcase
      return k;
    end
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h;
    begin
      case (i)
        3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
        3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
        3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
        3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
      endcase
      return h;
    end
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction
  function automatic logic [31:0] sig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction
  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction
  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sha256_stream_hasher_core.sv =====
// Top level: byte-stream SHA-256 hasher around a schedule memory.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid/in_ready, msg_byte, byte_present,     | sink
//          | end_of_message                                 |
//  out     | out_valid/out_ready, digest_word, word_index,  | source
//          | last_word                                      |
//
// A byte that neither fills a block nor ends the message keeps S_IDLE, so in_ready stays high.
// A block fill takes S_RD1 (load the working variables and start the first
// schedule reads), then 64 rounds of S_RD2 (read the t and t-7 words) and
// S_RND (compute and write back while reading the next round's t-15 and t-2
// words: the memory has two read ports).
// End of message: the padding bytes in S_PAD, plus one or two blocks, then
// eight digest transactions. Reset (rst, synchronous) restarts the message.
// in_ready drops while compressing, padding or draining the digest; the digest
// holds its word until out_ready.
`default_nettype none
module sha256_stream_hasher_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  msg_byte,
  input  wire logic        byte_present,
  input  wire logic        end_of_message,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);
  import sha256_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PAD  = 6'b000010,
    S_RD1  = 6'b000100,
    S_RD2  = 6'b001000,
    S_RND  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state;

  // schedule window: synchronous memory, two read ports, one write port
  logic [31:0] sched [SCHED_DEPTH];
  logic [3:0]  ra0, ra1;
  logic [31:0] rd0, rd1;
  logic        we;
  logic [3:0]  wa;
  logic [31:0] wd;

  always_ff @(posedge clk) begin
    if (we) sched[wa] <= wd;
    rd0 <= sched[ra0];
    rd1 <= sched[ra1];
  end

  logic [31:0] hw [DIGEST_WORDS];
  logic [31:0] va, vb, vc, vd, ve, vf, vg, vh;
  logic [31:0] x15, x2;       // held from first read pair
  logic [31:0] acc;           // word being packed
  logic [63:0] bit_length;
  logic [5:0]  pos;
  logic [6:0]  round;
  logic        pad_end;       // message closing: padding under way
  logic        len_phase;     // length bytes belong in this block
  logic [3:0]  pad_len_idx;   // 0: 0x80, 1..: zeros/length bytes
  logic [2:0]  oidx;
  logic [63:0] len_latch;

  // byte to push during padding
  logic [7:0] pad_b;
  always_comb begin
    if (pad_len_idx == 4'd0) pad_b = PAD_BYTE;
    else if (len_phase && pos >= LEN_POS) pad_b = len_latch[{~pos[2:0], 3'b000} +: 8];
    else pad_b = 8'h00;
  end

  logic [5:0]  t6;
  logic [31:0] w, t1, t2;
  assign t6 = round[5:0];
  always_comb begin
    if (round < 7'd16) w = rd0;
    else w = rd0 + sig0(x15) + rd1 + sig1(x2);
    t1 = vh + bsig1(ve) + ((ve & vf) ^ (~ve & vg)) + round_k(t6) + w;
    t2 = bsig0(va) + ((va & vb) ^ (va & vc) ^ (vb & vc));
  end

  assign in_ready    = (state == S_IDLE);
  assign out_valid   = (state == S_OUT);
  assign digest_word = hw[oidx];
  assign word_index  = oidx;
  assign last_word   = (oidx == 3'd7);

  // push one byte: pack, and write the word on its last byte
  logic       push;
  logic [7:0] push_b;
  logic [31:0] packed_w;
  assign packed_w = (pos[1:0] == 2'd0) ? {24'd0, push_b} : {acc[23:0], push_b};

  always_comb begin
    push   = 1'b0;
    push_b = msg_byte;
    if (state == S_IDLE && in_valid && byte_present) push = 1'b1;
    if (state == S_PAD) begin push = 1'b1; push_b = pad_b; end
    ra0 = 4'd0; ra1 = 4'd0; we = 1'b0; wa = pos[5:2]; wd = packed_w;
    if (push && pos[1:0] == 2'd3) we = 1'b1;
    // x15 and x2 of the round about to start
    if (state == S_RD1) begin ra0 = 4'(round + 7'd1); ra1 = 4'(round + 7'd14); end
    // round counter not yet advanced here
    if (state == S_RND) begin ra0 = 4'(round + 7'd2); ra1 = 4'(round + 7'd15); end
    if (state == S_RD2) begin
      ra0 = round[3:0];
      ra1 = 4'(round + 7'd9);
    end
    if (state == S_RND && round >= 7'd16) begin
      we = 1'b1; wa = round[3:0]; wd = w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bit_length <= '0; pos <= '0; round <= '0; pad_end <= 1'b0;
      len_phase <= 1'b0;
      pad_len_idx <= '0; oidx <= '0;
      for (int i = 0; i < DIGEST_WORDS; i++) hw[i] <= init_h(3'(i));
    end else begin
      if (push) begin
        acc <= packed_w;
        pos <= pos + 6'd1;
      end
      unique case (state)
        S_IDLE: if (in_valid) begin
          if (byte_present) bit_length <= bit_length + 64'd8;
          len_latch <= bit_length + (byte_present ? 64'd8 : 64'd0);
          pad_end <= end_of_message;
          len_phase <= 1'b0;
          pad_len_idx <= '0;
          if (byte_present && pos == 6'd63) begin
            state <= S_RD1; round <= '0;
          end else if (end_of_message) state <= S_PAD;
        end
        S_PAD: begin
          pad_len_idx <= (pad_len_idx == 4'd15) ? pad_len_idx : pad_len_idx + 4'd1;
          // 0x80 early enough: the length fits behind it in this block
          if (pad_len_idx == 4'd0 && pos < LEN_POS) len_phase <= 1'b1;
          if (pos == 6'd63) begin
            state <= S_RD1; round <= '0;
            // no length yet: one more block carries it
            pad_end <= !len_phase;
            len_phase <= 1'b1;
          end
        end
        S_RD1: begin
          {va, vb, vc, vd, ve, vf, vg, vh} <=
            {hw[0], hw[1], hw[2], hw[3], hw[4], hw[5], hw[6], hw[7]};
          state <= S_RD2;
        end
        S_RD2: begin
          x15 <= rd0; x2 <= rd1;
          state <= S_RND;
        end
        S_RND: begin
          {vb, vc, vd} <= {va, vb, vc};
          {vf, vg, vh} <= {ve, vf, vg};
          va <= t1 + t2;
          ve <= vd + t1;
          if (round == 7'd63) begin
            hw[0] <= hw[0] + t1 + t2; hw[1] <= hw[1] + va;
            hw[2] <= hw[2] + vb;      hw[3] <= hw[3] + vc;
            hw[4] <= hw[4] + vd + t1; hw[5] <= hw[5] + ve;
            hw[6] <= hw[6] + vf;      hw[7] <= hw[7] + vg;
            round <= '0;
            if (pad_end) state <= S_PAD;
            else if (pad_len_idx != 4'd0) begin state <= S_OUT; oidx <= '0; end
            else state <= S_IDLE;
          end else begin
            round <= round + 7'd1;
            state <= S_RD2;
          end
        end
        S_OUT: if (out_ready) begin
          oidx <= oidx + 3'd1;
          if (oidx == 3'd7) begin
            state <= S_IDLE; bit_length <= '0; pad_len_idx <= '0;
            for (int i = 0; i < DIGEST_WORDS; i++) hw[i] <= init_h(3'(i));
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while draining digest");
  a_round_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RND |-> round < 7'd64) else $error("round out of range");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(oidx)) else $error("digest dropped");
  a_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("state code");
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for the byte-stream SHA-256 hasher: directed and random messages against a local predictor.
`timescale 1ns / 1ps
`default_nettype none

class digest_scoreboard;
  bit [31:0] hash_st [8];
  bit [31:0] blk [16];
  bit [63:0] msg_bits;
  bit [5:0]  blk_pos;
  bit [31:0] exp_word [$];
  bit [2:0]  exp_idx [$];
  bit        exp_last [$];
  int        fails;
  int        words_seen;
  int        msgs_done;

  function new();
    fails = 0;
    words_seen = 0;
    msgs_done = 0;
    restart();
  endfunction

  function void restart();
    for (int i = 0; i < 8; i++) hash_st[i] = sha256_pkg::init_h(3'(i));
    msg_bits = '0;
    blk_pos = '0;
  endfunction

  function bit [31:0] rr(bit [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function void compress();
    bit [31:0] v [8];
    bit [31:0] w, x15, x2, t1, t2, k;
    for (int i = 0; i < 8; i++) v[i] = hash_st[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        w = blk[t];
      end else begin
        x15 = blk[(t - 15) & 15];
        x2 = blk[(t - 2) & 15];
        w = blk[t & 15] + (rr(x15, 7) ^ rr(x15, 18) ^ (x15 >> 3)) + blk[(t - 7) & 15]
            + (rr(x2, 17) ^ rr(x2, 19) ^ (x2 >> 10));
        blk[t & 15] = w;
      end
      k = sha256_pkg::round_k(6'(t));
      t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k + w;
      t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i - 1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_st[i] += v[i];
  endfunction

  function void add_byte(bit [7:0] b);
    if (blk_pos[1:0] == 0) blk[blk_pos[5:2]] = '0;
    blk[blk_pos[5:2]] = {blk[blk_pos[5:2]][23:0], b};
    blk_pos++;
    if (blk_pos == 0) compress();
  endfunction

  // accepted input transaction
  function void note_input(bit [7:0] b, bit present, bit eom);
    bit [63:0] len;
    if (present) begin
      add_byte(b);
      msg_bits += 8;
    end
    if (!eom) return;
    len = msg_bits;
    add_byte(sha256_pkg::PAD_BYTE);
    while (blk_pos != sha256_pkg::LEN_POS) add_byte(8'h00);
    for (int s = 56; s >= 0; s -= 8) add_byte(len[s +: 8]);
    for (int i = 0; i < 8; i++) begin
      exp_word.push_back(hash_st[i]);
      exp_idx.push_back(3'(i));
      exp_last.push_back(i == 7);
    end
    restart();
  endfunction

  function void check_word(bit [31:0] d, bit [2:0] idx, bit lst);
    words_seen++;
    if (lst) msgs_done++;
    if (exp_word.size() == 0) begin
      $display("%0t: unexpected digest word %h idx %0d", $time, d, idx);
      fails++;
      return;
    end
    if (exp_word[0] !== d || exp_idx[0] !== idx || exp_last[0] !== lst) begin
      $display("%0t: mismatch exp word %h idx %0d last %0d, got %h idx %0d last %0d",
               $time, exp_word[0], exp_idx[0], exp_last[0], d, idx, lst);
      fails++;
    end
    void'(exp_word.pop_front());
    void'(exp_idx.pop_front());
    void'(exp_last.pop_front());
  endfunction

  function int pending();
    return exp_word.size();
  endfunction
endclass

module tb;
  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  msg_byte;
  logic        byte_present;
  logic        end_of_message;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  digest_scoreboard sb;
  int  send_idle;   // percent of cycles the sender holds back
  int  recv_stall;  // percent of cycles the receiver stalls
  int  cycles;
  int  items_sent;

  sha256_stream_hasher_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .msg_byte(msg_byte), .byte_present(byte_present), .end_of_message(end_of_message),
    .out_valid(out_valid), .out_ready(out_ready),
    .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    sb = new();
    rst = 1;
    in_valid = 0;
    msg_byte = '0;
    byte_present = 0;
    end_of_message = 0;
    out_ready = 0;
    send_idle = 0;
    recv_stall = 0;
    cycles = 0;
    items_sent = 0;
  end

  // Watchdog: fails the run if it goes on far too long; a message costs at most two blocks plus stalls.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Receiver: random stall, drop decisions made on the falling edge.
  always @(negedge clk)
    out_ready <= !rst && ($urandom_range(99) >= recv_stall);

  // Output side: sample at the rising edge.
  always @(posedge clk)
    if (!rst && out_valid && out_ready) sb.check_word(digest_word, word_index, last_word);

  // One input transaction; valid stays up until accepted.
  task automatic send_item(bit [7:0] b, bit present, bit eom);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      msg_byte <= 8'($urandom);
      byte_present <= 1'($urandom);
      end_of_message <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1;
    msg_byte <= b;
    byte_present <= present;
    end_of_message <= eom;
    do @(posedge clk); while (!in_ready);
    sb.note_input(b, present, eom);
    items_sent++;
    @(negedge clk);
  endtask

  // Message of n data bytes; mostly well formed, some with no-data fillers
  // and with the final byte folded into the end transaction or not.
  task automatic send_message(int n, bit noisy);
    bit fold;
    fold = 1'($urandom_range(1));
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      if (fold && i == n - 1) send_item(8'($urandom), 1'b1, 1'b1);
      else send_item(8'($urandom), 1'b1, 1'b0);
    end
    if (!(fold && n > 0)) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // Whole messages until the running transaction count reaches until_items.
  task automatic run_phase(int idle, int stall, int until_items);
    send_idle = idle;
    recv_stall = stall;
    while (items_sent < until_items) begin
      case ($urandom_range(9))
        0: send_message($urandom_range(54, 57), 1'b1);    // around where padding spills into an extra block
        1: send_message($urandom_range(62, 66), 1'b1);    // around a block boundary
        default: send_message($urandom_range(0, 14), 1'($urandom_range(1)));
      endcase
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // Directed: empty message, byte extremes, no-data filler, data on the end item.
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    for (int i = 0; i < 3; i++) send_item(8'h55 << i, 1'b1, 1'b0);
    send_item(8'haa, 1'b0, 1'b1);
    // Random phases across idle/stall mixes.
    run_phase(0, 0, 60);
    run_phase(53, 0, 110);
    run_phase(0, 53, 160);
    run_phase(23, 23, 205);
    in_valid <= 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("tb: %0d input transactions, %0d messages, %0d digest words checked",
             items_sent, sb.msgs_done, sb.words_seen);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
